// ----- design/bgr_pkg.sv -----
// ----------------------------------------------------------------------------
// bgr_pkg
// Shared widths, constants and register codes of the bitmap glyph rasterizer.
// ----------------------------------------------------------------------------
`default_nettype none

package bgr_pkg;

    // font store geometry
    localparam int FONT_BYTES = 2048;
    localparam int FONT_AW    = $clog2(FONT_BYTES);
    localparam int BYTE_W     = 8;

    // glyph limits
    localparam int MAX_WIDTH  = 8;
    localparam int MAX_HEIGHT = 8;
    localparam int COL_W      = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int BIT_W      = $clog2(BYTE_W);

    // first glyph byte sits after the font header
    localparam logic [FONT_AW-1:0] GLYPH_BASE = FONT_AW'(5);

    // field widths
    localparam int DIM_W   = 4;
    localparam int CODE_W  = 8;
    localparam int OX_W    = 7;
    localparam int OY_W    = 6;
    localparam int PIX_W   = 8;

    // stream packing
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 24;

    // configuration port
    localparam int CFG_AW = 2;
    localparam int CFG_DW = 8;

    typedef enum logic [CFG_AW-1:0] {
        CFG_HEIGHT = 2'd0,
        CFG_WIDTH  = 2'd1,
        CFG_FIRST  = 2'd2,
        CFG_LAST   = 2'd3
    } cfg_idx_t;

    // item kinds carried on s_tuser
    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_DRAW = 1'b1;

endpackage

`default_nettype wire

// ----- design/bgr_ram.sv -----
// ----------------------------------------------------------------------------
// bgr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bgr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port, holds its data while re is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- design/bitmap_glyph_rasterizer.sv -----
// ----------------------------------------------------------------------------
// bitmap_glyph_rasterizer
// Turns one character of a column-major bitmap font into pixel writes.
// ----------------------------------------------------------------------------
// A load request (s_tuser = 0) writes one byte into the 2048-byte font RAM.
// A draw request (s_tuser = 1) whose code lies within first_code..last_code
// is walked column by column: each column byte is shifted out LSB first as
// eight set-or-clear pixel writes, the final one flagged with m_tlast. A draw
// goes through these steps: accept the request and form the glyph offset,
// read the font RAM at the base address, load the first column byte, then
// one pixel per cycle while the output is not stalled. The single font RAM
// read port and a shared address adder fetch the next column during the
// current one. s_tready stays low during a draw; a draw with an out-of-range
// code, zero width or zero height gives no writes. The default glyph has five
// columns.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_glyph_rasterizer (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // configuration
    input  wire logic                          cfg_we,
    input  wire logic [bgr_pkg::CFG_AW-1:0]    cfg_addr,
    input  wire logic [bgr_pkg::CFG_DW-1:0]    cfg_wdata,
    // request side
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // load_addr[10:0], load_byte[18:11], char_code[26:19],
    // origin_x[33:27], origin_y[39:34]
    input  wire logic [bgr_pkg::S_DATA_W-1:0]  s_tdata,
    // mode[0]
    input  wire logic                          s_tuser,
    // pixel write side
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // pixel_x[7:0], pixel_y[15:8], pixel_on[16], zero fill [23:17]
    output logic      [bgr_pkg::M_DATA_W-1:0]  m_tdata,
    // last_pixel
    output logic                               m_tlast
);

    import bgr_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BASE,
        ST_LOAD,
        ST_EMIT
    } state_t;

    // configuration registers
    logic [DIM_W-1:0]  height_reg;
    logic [DIM_W-1:0]  width_reg;
    logic [CODE_W-1:0] first_reg;
    logic [CODE_W-1:0] last_reg;

    // sequencer and datapath registers
    state_t              state_reg, state_next;
    logic [FONT_AW-1:0]  offset_reg, offset_next;
    logic [FONT_AW-1:0]  addr_reg, addr_next;
    logic [OX_W-1:0]     ox_reg, ox_next;
    logic [OY_W-1:0]     oy_reg, oy_next;
    logic [COL_W-1:0]    col_last_reg, col_last_next;
    logic [COL_W-1:0]    col_reg, col_next;
    logic [BIT_W-1:0]    bit_reg, bit_next;
    logic [BYTE_W-1:0]   shift_reg, shift_next;

    // output register
    logic                m_valid_reg, m_valid_next;
    logic [PIX_W-1:0]    px_reg, px_next;
    logic [PIX_W-1:0]    py_reg, py_next;
    logic                pon_reg, pon_next;
    logic                plast_reg, plast_next;

    // request fields
    logic [FONT_AW-1:0]  in_load_addr;
    logic [BYTE_W-1:0]   in_load_byte;
    logic [CODE_W-1:0]   in_code;
    logic [OX_W-1:0]     in_ox;
    logic [OY_W-1:0]     in_oy;

    logic                in_accept;
    logic                draw_ok;
    logic [DIM_W-1:0]    width_eff;
    logic [CODE_W-1:0]   code_diff;
    logic [FONT_AW-1:0]  sum_a, sum_b, addr_sum;
    logic                rd_en;
    logic [BYTE_W-1:0]   rd_data;
    logic                out_free;
    logic                out_load;
    logic                col_end;
    logic                glyph_end;

    assign in_load_addr = s_tdata[10:0];
    assign in_load_byte = s_tdata[18:11];
    assign in_code      = s_tdata[26:19];
    assign in_ox        = s_tdata[33:27];
    assign in_oy        = s_tdata[39:34];

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            height_reg <= DIM_W'(8);
            width_reg  <= DIM_W'(5);
            first_reg  <= CODE_W'(32);
            last_reg   <= CODE_W'(127);
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_addr))
                CFG_HEIGHT: height_reg <= cfg_wdata[DIM_W-1:0];
                CFG_WIDTH:  width_reg  <= cfg_wdata[DIM_W-1:0];
                CFG_FIRST:  first_reg  <= cfg_wdata[CODE_W-1:0];
                CFG_LAST:   last_reg   <= cfg_wdata[CODE_W-1:0];
                default:    ;
            endcase
        end
    end

    // glyph width clamped to the widest supported glyph
    assign width_eff = (width_reg > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : width_reg;
    assign code_diff = in_code - first_reg;

    // every nonzero height up to MAX_HEIGHT fits in one byte per column
    assign draw_ok = (in_code >= first_reg) && (in_code <= last_reg)
                     && (width_eff != '0) && (height_reg != '0);

    // shared address adder: glyph base, then one step per column
    always_comb
    begin
        if (state_reg == ST_BASE)
        begin
            sum_a = offset_reg;
            sum_b = GLYPH_BASE;
        end
        else
        begin
            sum_a = addr_reg;
            sum_b = FONT_AW'(1);
        end
    end
    assign addr_sum = sum_a + sum_b;

    assign out_free  = !m_valid_reg || m_tready;
    assign out_load  = (state_reg == ST_EMIT) && out_free;
    assign col_end   = (bit_reg == BIT_W'(BYTE_W - 1));
    assign glyph_end = col_end && (col_reg == col_last_reg);

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        offset_next   = offset_reg;
        addr_next     = addr_reg;
        ox_next       = ox_reg;
        oy_next       = oy_reg;
        col_last_next = col_last_reg;
        col_next      = col_reg;
        bit_next      = bit_reg;
        shift_next    = shift_reg;
        rd_en         = 1'b0;
        m_valid_next  = m_valid_reg && !m_tready;
        px_next       = px_reg;
        py_next       = py_reg;
        pon_next      = pon_reg;
        plast_next    = plast_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && (s_tuser == MODE_DRAW) && draw_ok)
                begin
                    offset_next   = FONT_AW'(code_diff) * FONT_AW'(width_eff);
                    ox_next       = in_ox;
                    oy_next       = in_oy;
                    col_last_next = COL_W'(width_eff - DIM_W'(1));
                    state_next    = ST_BASE;
                end
            end
            ST_BASE:
            begin
                // read the first column byte
                rd_en      = 1'b1;
                addr_next  = addr_sum;
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                // take the first byte, prefetch the next column
                shift_next = rd_data;
                rd_en      = 1'b1;
                addr_next  = addr_sum;
                col_next   = '0;
                bit_next   = '0;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    px_next      = PIX_W'(ox_reg) + PIX_W'(col_reg);
                    py_next      = PIX_W'(oy_reg) + PIX_W'(bit_reg);
                    pon_next     = shift_reg[0];
                    plast_next   = glyph_end;
                    if (glyph_end)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (col_end)
                    begin
                        shift_next = rd_data;
                        rd_en      = 1'b1;
                        addr_next  = addr_sum;
                        col_next   = col_reg + COL_W'(1);
                        bit_next   = '0;
                    end
                    else
                    begin
                        shift_next = shift_reg >> 1;
                        bit_next   = bit_reg + BIT_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        offset_reg   <= offset_next;
        addr_reg     <= addr_next;
        ox_reg       <= ox_next;
        oy_reg       <= oy_next;
        col_last_reg <= col_last_next;
        col_reg      <= col_next;
        bit_reg      <= bit_next;
        shift_reg    <= shift_next;
        px_reg       <= px_next;
        py_reg       <= py_next;
        pon_reg      <= pon_next;
        plast_reg    <= plast_next;
    end

    // font store
    bgr_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (FONT_BYTES)
    ) u_font_ram (
        .clk   (clk),
        .we    (in_accept && (s_tuser == MODE_LOAD)),
        .waddr (in_load_addr),
        .wdata (in_load_byte),
        .re    (rd_en),
        .raddr (addr_sum),
        .rdata (rd_data)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {(M_DATA_W - 2 * PIX_W - 1)'(0), pon_reg, py_reg, px_reg};
    assign m_tlast  = plast_reg;

`ifndef ASSERT_OFF
    // a valid draw request starts the address phase
    assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && (s_tuser == MODE_DRAW) && draw_ok |=> state_reg == ST_BASE)
        else $error("draw request did not start glyph walk");

    // the flagged last pixel ends the walk
    assert property (@(posedge clk) disable iff (!rst_n)
        out_load && glyph_end |=> state_reg == ST_IDLE && m_valid_reg && plast_reg)
        else $error("glyph walk did not end on last pixel");

    // a stalled output freezes the pixel walk
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT && !out_free |=>
            $stable(bit_reg) && $stable(col_reg) && $stable(shift_reg))
        else $error("pixel walk advanced while output stalled");

    // a load request never enters the walk
    assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && (s_tuser == MODE_LOAD) |=> state_reg == ST_IDLE)
        else $error("load request started a glyph walk");
`endif

endmodule

`default_nettype wire
